// ----- rtl/rsi_pkg.sv -----
`timescale 1ns / 1ps

package rsi_pkg;

  // Fraction bits of the ray parameter held between divider and point math.
  localparam int FRAC_BITS = 16;

  // Signed width of a cross product difference.
  localparam int CW = 67;
  // Dividend and quotient width: numerator shifted up by the fraction bits.
  localparam int DW = CW + FRAC_BITS;
  // Divider partial remainder width.
  localparam int RW = CW + 1;
  // Number of 32-bit chunks the quotient is split into for the point multiply.
  localparam int NCH = (DW + 31) / 32;
  // Width of the unsigned direction times quotient product.
  localparam int SW = NCH * 32 + 32;

  // Per-item data carried alongside the divider.
  typedef struct packed {
    logic               hit;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
  } pass_t;

endpackage

// ----- rtl/ray_segment_intersection_core.sv -----
`timescale 1ns / 1ps

// Ray / line segment intersection in signed Q16.16. One word is accepted per
// cycle and one result word leaves per item, in order. Four stages form the
// differences, cross products, their sums and the hit test, a restoring
// divider resolves one quotient bit per stage over DW stages, and four more
// stages multiply, shift, add the origin and saturate. The whole pipeline
// advances together and holds while a result word waits on out_ready.
module ray_segment_intersection_core import rsi_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_ray_origin_x,
  input  logic signed [31:0] in_ray_origin_y,
  input  logic signed [31:0] in_ray_dir_x,
  input  logic signed [31:0] in_ray_dir_y,
  input  logic signed [31:0] in_seg_start_x,
  input  logic signed [31:0] in_seg_start_y,
  input  logic signed [31:0] in_seg_end_x,
  input  logic signed [31:0] in_seg_end_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_hit,
  output logic signed [31:0] out_point_x,
  output logic signed [31:0] out_point_y
);

  logic ce;
  logic out_valid_r;

  // The pipeline moves whenever the output register is free or being taken.
  assign ce       = !out_valid_r || out_ready;
  assign in_ready = ce;

  // Stage 1: segment direction and origin-to-start vector.
  logic               s1_v_r;
  pass_t              s1_p_r;
  logic signed [32:0] s1_lx_r, s1_ly_r, s1_gx_r, s1_gy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (ce) begin
      s1_v_r <= in_valid;
    end
    if (ce) begin
      s1_p_r.hit <= 1'b0;
      s1_p_r.ox  <= in_ray_origin_x;
      s1_p_r.oy  <= in_ray_origin_y;
      s1_p_r.dx  <= in_ray_dir_x;
      s1_p_r.dy  <= in_ray_dir_y;
      s1_lx_r    <= {in_seg_end_x[31], in_seg_end_x} - {in_seg_start_x[31], in_seg_start_x};
      s1_ly_r    <= {in_seg_end_y[31], in_seg_end_y} - {in_seg_start_y[31], in_seg_start_y};
      s1_gx_r    <= {in_seg_start_x[31], in_seg_start_x} - {in_ray_origin_x[31], in_ray_origin_x};
      s1_gy_r    <= {in_seg_start_y[31], in_seg_start_y} - {in_ray_origin_y[31], in_ray_origin_y};
    end
  end

  // Stage 2: the six products of the cross products.
  logic               s2_v_r;
  pass_t              s2_p_r;
  logic signed [65:0] s2_dly_r, s2_dylx_r, s2_gxly_r, s2_gylx_r, s2_gxdy_r, s2_gydx_r;
  logic signed [32:0] dx33, dy33;

  assign dx33 = {s1_p_r.dx[31], s1_p_r.dx};
  assign dy33 = {s1_p_r.dy[31], s1_p_r.dy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (ce) begin
      s2_v_r <= s1_v_r;
    end
    if (ce) begin
      s2_p_r    <= s1_p_r;
      s2_dly_r  <= dx33 * s1_ly_r;
      s2_dylx_r <= dy33 * s1_lx_r;
      s2_gxly_r <= s1_gx_r * s1_ly_r;
      s2_gylx_r <= s1_gy_r * s1_lx_r;
      s2_gxdy_r <= s1_gx_r * dy33;
      s2_gydx_r <= s1_gy_r * dx33;
    end
  end

  // Stage 3: denominator and the two numerators.
  logic                 s3_v_r;
  pass_t                s3_p_r;
  logic signed [CW-1:0] s3_den_r, s3_n1_r, s3_n2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (ce) begin
      s3_v_r <= s2_v_r;
    end
    if (ce) begin
      s3_p_r   <= s2_p_r;
      s3_den_r <= CW'(s2_dly_r) - CW'(s2_dylx_r);
      s3_n1_r  <= CW'(s2_gxly_r) - CW'(s2_gylx_r);
      s3_n2_r  <= CW'(s2_gxdy_r) - CW'(s2_gydx_r);
    end
  end

  // Stage 4: make the denominator positive and decide the hit exactly.
  logic [CW-1:0] den_a, n1_a, n2_a;
  logic          den_neg, hit_pre;
  pass_t         s4_p;

  assign den_neg = s3_den_r[CW-1];
  assign den_a   = den_neg ? (CW'(0) - s3_den_r) : s3_den_r;
  assign n1_a    = den_neg ? (CW'(0) - s3_n1_r) : s3_n1_r;
  assign n2_a    = den_neg ? (CW'(0) - s3_n2_r) : s3_n2_r;
  assign hit_pre = (s3_den_r != '0) && !n1_a[CW-1] && !n2_a[CW-1] && (den_a >= n2_a);

  always_comb begin
    s4_p     = s3_p_r;
    s4_p.hit = hit_pre;
  end

  // Divider stages: index 0 is the hit-test stage, each later one adds a bit.
  logic          dv_v_r   [0:DW];
  pass_t         dv_p_r   [0:DW];
  logic [CW-1:0] dv_den_r [0:DW];
  logic [RW-1:0] dv_rem_r [0:DW];
  logic [DW-1:0] dv_num_r [0:DW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (ce) begin
      dv_v_r[0] <= s3_v_r;
    end
    if (ce) begin
      dv_p_r[0]   <= s4_p;
      dv_den_r[0] <= den_a;
      dv_rem_r[0] <= '0;
      dv_num_r[0] <= {n1_a, {FRAC_BITS{1'b0}}};
    end
  end

  for (genvar k = 0; k < DW; k++) begin : g_div
    logic [RW-1:0] trial;
    logic          ge;

    // Shift in the next dividend bit and subtract where the divisor fits.
    assign trial = {dv_rem_r[k][RW-2:0], dv_num_r[k][DW-1]};
    assign ge    = trial >= {1'b0, dv_den_r[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else if (ce) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
      if (ce) begin
        dv_p_r[k+1]   <= dv_p_r[k];
        dv_den_r[k+1] <= dv_den_r[k];
        dv_rem_r[k+1] <= ge ? (trial - {1'b0, dv_den_r[k]}) : trial;
        dv_num_r[k+1] <= {dv_num_r[k][DW-2:0], ge};
      end
    end
  end

  // Point stage 1: direction magnitude times 32-bit chunks of the quotient.
  logic [NCH*32-1:0] qpad;
  logic [31:0]       adx, ady;
  pass_t             dv_last;

  assign dv_last = dv_p_r[DW];
  assign qpad    = {{(NCH*32-DW){1'b0}}, dv_num_r[DW]};
  assign adx     = dv_last.dx[31] ? (32'd0 - dv_last.dx) : dv_last.dx;
  assign ady     = dv_last.dy[31] ? (32'd0 - dv_last.dy) : dv_last.dy;

  logic        m1_v_r;
  pass_t       m1_p_r;
  logic [63:0] m1_ppx_r [0:NCH-1];
  logic [63:0] m1_ppy_r [0:NCH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
    end else if (ce) begin
      m1_v_r <= dv_v_r[DW];
    end
    if (ce) begin
      m1_p_r <= dv_last;
      for (int c = 0; c < NCH; c++) begin
        m1_ppx_r[c] <= adx * qpad[c*32 +: 32];
        m1_ppy_r[c] <= ady * qpad[c*32 +: 32];
      end
    end
  end

  // Point stage 2: sum the partial products.
  logic [SW-1:0] sum_x, sum_y;

  always_comb begin
    sum_x = '0;
    sum_y = '0;
    for (int c = 0; c < NCH; c++) begin
      sum_x = sum_x + (SW'(m1_ppx_r[c]) << (c * 32));
      sum_y = sum_y + (SW'(m1_ppy_r[c]) << (c * 32));
    end
  end

  logic          m2_v_r;
  pass_t         m2_p_r;
  logic [SW-1:0] m2_sx_r, m2_sy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_v_r <= 1'b0;
    end else if (ce) begin
      m2_v_r <= m1_v_r;
    end
    if (ce) begin
      m2_p_r  <= m1_p_r;
      m2_sx_r <= sum_x;
      m2_sy_r <= sum_y;
    end
  end

  // Point stage 3: restore the sign, floor-shift the fraction off, add origin.
  logic signed [SW:0]   px_s, py_s;
  logic signed [SW+1:0] cx, cy;

  assign px_s = m2_p_r.dx[31] ? ((SW+1)'(0) - {1'b0, m2_sx_r}) : {1'b0, m2_sx_r};
  assign py_s = m2_p_r.dy[31] ? ((SW+1)'(0) - {1'b0, m2_sy_r}) : {1'b0, m2_sy_r};
  assign cx   = {px_s[SW], px_s >>> FRAC_BITS} + (SW+2)'(m2_p_r.ox);
  assign cy   = {py_s[SW], py_s >>> FRAC_BITS} + (SW+2)'(m2_p_r.oy);

  logic                 m3_v_r;
  logic                 m3_hit_r;
  logic signed [SW+1:0] m3_cx_r, m3_cy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m3_v_r <= 1'b0;
    end else if (ce) begin
      m3_v_r <= m2_v_r;
    end
    if (ce) begin
      m3_hit_r <= m2_p_r.hit;
      m3_cx_r  <= cx;
      m3_cy_r  <= cy;
    end
  end

  // Output stage: saturate to 32 bits and zero the point on a miss.
  logic [31:0] sat_x, sat_y;

  always_comb begin
    if (!m3_cx_r[SW+1] && (m3_cx_r[SW:31] != '0)) begin
      sat_x = 32'h7FFF_FFFF;
    end else if (m3_cx_r[SW+1] && (m3_cx_r[SW:31] != '1)) begin
      sat_x = 32'h8000_0000;
    end else begin
      sat_x = m3_cx_r[31:0];
    end
    if (!m3_cy_r[SW+1] && (m3_cy_r[SW:31] != '0)) begin
      sat_y = 32'h7FFF_FFFF;
    end else if (m3_cy_r[SW+1] && (m3_cy_r[SW:31] != '1)) begin
      sat_y = 32'h8000_0000;
    end else begin
      sat_y = m3_cy_r[31:0];
    end
  end

  logic        hit_r;
  logic [31:0] px_r, py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ce) begin
      out_valid_r <= m3_v_r;
    end
    if (ce) begin
      hit_r <= m3_hit_r;
      px_r  <= m3_hit_r ? sat_x : 32'd0;
      py_r  <= m3_hit_r ? sat_y : 32'd0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = hit_r;
  assign out_point_x = px_r;
  assign out_point_y = py_r;

endmodule
